// File: sv/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types and codes for the vertex normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

  localparam int MAX_VERTICES_DEF = 1024;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_TRI   = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam int POS_W = 24;
  localparam int SUM_W = 62;
  localparam int POS_WORD_W = 3 * POS_W + 1;
  localparam int ACC_WORD_W = 3 * SUM_W;

  typedef struct packed {
    logic [1:0]         action;
    logic [9:0]         vertex_index;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [10:0]        corner_a;
    logic [10:0]        corner_b;
    logic [10:0]        corner_c;
  } req_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
  } rsp_word_t;

  typedef struct packed {
    logic               done;
    logic               zero;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } norm_rsp_t;

endpackage

// File: sv/vna_if.sv
// ----------------------------------------------------------------------------
// vna_req_if / vna_rsp_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface vna_req_if;
  import vna_pkg::*;
  logic      valid;
  logic      ready;
  req_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface vna_rsp_if;
  import vna_pkg::*;
  logic      valid;
  logic      ready;
  rsp_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: sv/vna_ram.sv
// ----------------------------------------------------------------------------
// vna_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module vna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/vna_norm.sv
// ----------------------------------------------------------------------------
// vna_norm
// Iterative normalizer: scales a 62-bit sum vector to unit length in Q1.14.
// ----------------------------------------------------------------------------
module vna_norm (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [vna_pkg::SUM_W-1:0] sum_x,
  input  logic [vna_pkg::SUM_W-1:0] sum_y,
  input  logic [vna_pkg::SUM_W-1:0] sum_z,
  output vna_pkg::norm_rsp_t       rsp
);
  import vna_pkg::*;

  typedef enum logic [8:0] {
    N_IDLE   = 9'b000000001,
    N_MAX    = 9'b000000010,
    N_SHIFT  = 9'b000000100,
    N_SQ     = 9'b000001000,
    N_ROOT   = 9'b000010000,
    N_DINIT  = 9'b000100000,
    N_DSTEP  = 9'b001000000,
    N_DSTORE = 9'b010000000,
    N_DONE   = 9'b100000000
  } nstate_t;

  nstate_t            state;
  logic [SUM_W-1:0]   mag [3];
  logic               neg [3];
  logic [SUM_W-1:0]   m;
  logic [59:0]        prod;
  logic [SUM_W-1:0]   sq;
  logic [SUM_W-1:0]   s;
  logic [62:0]        root;
  logic [62:0]        bitv;
  logic [4:0]         cnt;
  logic [1:0]         ci;
  logic [32:0]        rem;
  logic [32:0]        d;
  logic [15:0]        numlo;
  logic [15:0]        q;
  logic               zero;
  logic signed [15:0] ox, oy, oz;

  logic [62:0]        trial;
  logic [45:0]        num;
  logic [33:0]        r2;
  logic [15:0]        qs;
  logic [SUM_W-1:0]   mxy;

  assign trial = root + bitv;
  assign num   = {1'b0, mag[ci][29:0], 15'b0} + 46'(root[31:0]);
  assign r2    = {rem, numlo[15]};
  assign qs    = neg[ci] ? (16'd0 - q) : q;
  assign mxy   = (mag[0] > mag[1]) ? mag[0] : mag[1];

  assign rsp.done = (state == N_DONE);
  assign rsp.zero = zero;
  assign rsp.x    = ox;
  assign rsp.y    = oy;
  assign rsp.z    = oz;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      unique case (state)
        N_IDLE: begin
          if (start) begin
            neg[0] <= sum_x[SUM_W-1];
            neg[1] <= sum_y[SUM_W-1];
            neg[2] <= sum_z[SUM_W-1];
            mag[0] <= sum_x[SUM_W-1] ? (SUM_W'(0) - sum_x) : sum_x;
            mag[1] <= sum_y[SUM_W-1] ? (SUM_W'(0) - sum_y) : sum_y;
            mag[2] <= sum_z[SUM_W-1] ? (SUM_W'(0) - sum_z) : sum_z;
            zero   <= 1'b0;
            ox     <= '0;
            oy     <= '0;
            oz     <= '0;
            state  <= N_MAX;
          end
        end
        N_MAX: begin
          m <= (mxy > mag[2]) ? mxy : mag[2];
          if (mag[0] == '0 && mag[1] == '0 && mag[2] == '0) begin
            zero  <= 1'b1;
            state <= N_DONE;
          end else begin
            state <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          if (m[SUM_W-1:29] == '0) begin
            m      <= m << 1;
            mag[0] <= mag[0] << 1;
            mag[1] <= mag[1] << 1;
            mag[2] <= mag[2] << 1;
          end else if (m[SUM_W-1:30] != '0) begin
            m      <= m >> 1;
            mag[0] <= mag[0] >> 1;
            mag[1] <= mag[1] >> 1;
            mag[2] <= mag[2] >> 1;
          end else begin
            cnt   <= '0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          if (cnt != 5'd3) begin
            prod <= mag[cnt[1:0]][29:0] * mag[cnt[1:0]][29:0];
          end
          if (cnt == 5'd1) begin
            sq <= SUM_W'(prod);
          end else if (cnt == 5'd2) begin
            sq <= sq + SUM_W'(prod);
          end
          if (cnt == 5'd3) begin
            s     <= sq + SUM_W'(prod);
            root  <= '0;
            bitv  <= 63'(1) << 62;
            cnt   <= '0;
            state <= N_ROOT;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        N_ROOT: begin
          if ({1'b0, s} >= trial) begin
            s    <= s - trial[SUM_W-1:0];
            root <= (root >> 1) + bitv;
          end else begin
            root <= root >> 1;
          end
          bitv <= bitv >> 2;
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            ci    <= '0;
            state <= N_DINIT;
          end
        end
        N_DINIT: begin
          rem   <= 33'(num[45:16]);
          numlo <= num[15:0];
          d     <= {root[31:0], 1'b0};
          q     <= '0;
          cnt   <= '0;
          state <= N_DSTEP;
        end
        N_DSTEP: begin
          if (r2 >= {1'b0, d}) begin
            rem <= 33'(r2 - {1'b0, d});
            q   <= {q[14:0], 1'b1};
          end else begin
            rem <= r2[32:0];
            q   <= {q[14:0], 1'b0};
          end
          numlo <= numlo << 1;
          cnt   <= cnt + 5'd1;
          if (cnt == 5'd15) begin
            state <= N_DSTORE;
          end
        end
        N_DSTORE: begin
          priority case (ci)
            2'd0:    ox <= qs;
            2'd1:    oy <= qs;
            default: oz <= qs;
          endcase
          if (ci == 2'd2) begin
            state <= N_DONE;
          end else begin
            ci    <= ci + 2'd1;
            state <= N_DINIT;
          end
        end
        N_DONE: begin
          state <= N_IDLE;
        end
        default: begin
          state <= N_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/vertex_normal_accumulator_top.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_top
// Area-weighted smooth vertex normals over a position RAM and a sum RAM.
//
//   channel  dir  handshake      word
//   req      in   valid/ready    req_word_t (action, index, position, corners)
//   rsp      out  valid/ready    rsp_word_t (status, Q1.14 normal)
//
// Load: one position write, none for a bad slot. Triangle: three position
// reads, six products on one multiplier, three sum read-modify-writes; a bad
// corner ends it after the position reads. Read: the shift search, the 32-step
// square root and three 16-step divides in vna_norm; a zero sum skips all but
// the first check, a bad slot skips vna_norm. Clear: one RAM entry a cycle.
// After reset the same sweep runs with req.ready low.
// One item at a time; a waiting response does not block the next request.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator_top #(
  parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF
) (
  input logic        clk,
  input logic        rst,
  vna_req_if.sink    req,
  vna_rsp_if.source  rsp
);
  import vna_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam logic [16:0] MAXV = 17'(MAX_VERTICES);
  localparam logic [AW-1:0] LAST = AW'(MAX_VERTICES - 1);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_SWEEP   = 12'b000000000010,
    S_LOAD    = 12'b000000000100,
    S_TRI_RD  = 12'b000000001000,
    S_TRI_CHK = 12'b000000010000,
    S_CROSS   = 12'b000000100000,
    S_ACC_RD  = 12'b000001000000,
    S_ACC_WR  = 12'b000010000000,
    S_RD_RD   = 12'b000100000000,
    S_RD_CHK  = 12'b001000000000,
    S_RD_WAIT = 12'b010000000000,
    S_FIN     = 12'b100000000000
  } state_t;

  state_t                  state;
  logic [AW-1:0]           sweep_addr;
  logic                    sweep_reply;
  logic [AW-1:0]           slot;
  logic                    slot_bad;
  logic [AW-1:0]           ia, ib, ic;
  logic                    tri_bad;
  logic [2:0]              cnt;
  logic [1:0]              cj;
  logic signed [23:0]      hx, hy, hz;
  logic [POS_WORD_W-1:0]   pa, pb, pc;
  logic signed [24:0]      ux, uy, uz, wx, wy, wz;
  logic signed [49:0]      prod;
  logic signed [50:0]      nx, ny, nz;
  logic [1:0]              res_status;
  logic signed [15:0]      res_x, res_y, res_z;

  logic                    p_we;
  logic [AW-1:0]           p_waddr, p_raddr;
  logic [POS_WORD_W-1:0]   p_wdata, p_rdata;
  logic                    a_we;
  logic [AW-1:0]           a_waddr, a_raddr;
  logic [ACC_WORD_W-1:0]   a_wdata, a_rdata;

  logic [16:0]             idx_ext, ca_ext, cb_ext, cc_ext;
  logic [16:0]             ca_m1, cb_m1, cc_m1;
  logic signed [24:0]      opa, opb;
  logic [AW-1:0]           cur_corner;
  logic signed [SUM_W-1:0] nx_ext, ny_ext, nz_ext;
  logic                    nstart;
  norm_rsp_t               nrsp;

  assign idx_ext = {7'b0, req.data.vertex_index};
  assign ca_ext  = {6'b0, req.data.corner_a};
  assign cb_ext  = {6'b0, req.data.corner_b};
  assign cc_ext  = {6'b0, req.data.corner_c};
  assign ca_m1   = ca_ext - 17'd1;
  assign cb_m1   = cb_ext - 17'd1;
  assign cc_m1   = cc_ext - 17'd1;
  assign nx_ext  = SUM_W'(nx);
  assign ny_ext  = SUM_W'(ny);
  assign nz_ext  = SUM_W'(nz);

  assign req.ready = (state == S_IDLE);
  assign nstart    = (state == S_RD_CHK) && !slot_bad && p_rdata[POS_WORD_W-1];

  vna_ram #(.WIDTH(POS_WORD_W), .DEPTH(MAX_VERTICES)) u_pos_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  vna_ram #(.WIDTH(ACC_WORD_W), .DEPTH(MAX_VERTICES)) u_acc_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  vna_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (nstart),
    .sum_x (a_rdata[3*SUM_W-1:2*SUM_W]),
    .sum_y (a_rdata[2*SUM_W-1:SUM_W]),
    .sum_z (a_rdata[SUM_W-1:0]),
    .rsp   (nrsp)
  );

  always_comb begin
    priority case (cj)
      2'd0:    cur_corner = ia;
      2'd1:    cur_corner = ib;
      default: cur_corner = ic;
    endcase
  end

  always_comb begin
    priority case (cnt)
      3'd0:    begin opa = uy; opb = wz; end
      3'd1:    begin opa = uz; opb = wy; end
      3'd2:    begin opa = uz; opb = wx; end
      3'd3:    begin opa = ux; opb = wz; end
      3'd4:    begin opa = ux; opb = wy; end
      default: begin opa = uy; opb = wx; end
    endcase
  end

  always_comb begin
    p_we    = 1'b0;
    p_waddr = slot;
    p_wdata = {1'b1, hx, hy, hz};
    a_we    = 1'b0;
    a_waddr = cur_corner;
    a_wdata = {a_rdata[3*SUM_W-1:2*SUM_W] + nx_ext,
               a_rdata[2*SUM_W-1:SUM_W] + ny_ext,
               a_rdata[SUM_W-1:0] + nz_ext};
    a_raddr = (state == S_RD_RD) ? slot : cur_corner;
    priority case (cnt)
      3'd0:    p_raddr = ia;
      3'd1:    p_raddr = ib;
      default: p_raddr = ic;
    endcase
    if (state == S_RD_RD) begin
      p_raddr = slot;
    end
    if (state == S_SWEEP) begin
      p_we    = 1'b1;
      p_waddr = sweep_addr;
      p_wdata = '0;
      a_we    = 1'b1;
      a_waddr = sweep_addr;
      a_wdata = '0;
    end
    if (state == S_LOAD) begin
      p_we = !slot_bad;
    end
    if (state == S_ACC_WR) begin
      a_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      sweep_addr  <= '0;
      sweep_reply <= 1'b0;
      rsp.valid   <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_FIN) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            res_status <= ST_OK;
            res_x      <= '0;
            res_y      <= '0;
            res_z      <= '0;
            slot       <= idx_ext[AW-1:0];
            slot_bad   <= (idx_ext >= MAXV);
            hx         <= req.data.pos_x;
            hy         <= req.data.pos_y;
            hz         <= req.data.pos_z;
            ia         <= ca_m1[AW-1:0];
            ib         <= cb_m1[AW-1:0];
            ic         <= cc_m1[AW-1:0];
            tri_bad    <= (ca_ext == '0) || (ca_ext > MAXV) ||
                          (cb_ext == '0) || (cb_ext > MAXV) ||
                          (cc_ext == '0) || (cc_ext > MAXV);
            cnt        <= '0;
            unique case (req.data.action)
              ACT_LOAD:  state <= S_LOAD;
              ACT_TRI:   state <= S_TRI_RD;
              ACT_READ:  state <= S_RD_RD;
              ACT_CLEAR: begin
                sweep_addr  <= '0;
                sweep_reply <= 1'b1;
                state       <= S_SWEEP;
              end
            endcase
          end
        end
        S_SWEEP: begin
          sweep_addr <= sweep_addr + AW'(1);
          if (sweep_addr == LAST) begin
            state <= sweep_reply ? S_FIN : S_IDLE;
          end
        end
        S_LOAD: begin
          if (slot_bad) begin
            res_status <= ST_BAD;
          end
          state <= S_FIN;
        end
        S_TRI_RD: begin
          cnt <= cnt + 3'd1;
          priority case (cnt)
            3'd1:    pa <= p_rdata;
            3'd2:    pb <= p_rdata;
            3'd3:    pc <= p_rdata;
            default: ;
          endcase
          if (cnt == 3'd3) begin
            state <= S_TRI_CHK;
          end
        end
        S_TRI_CHK: begin
          ux  <= 25'(signed'(pb[71:48])) - 25'(signed'(pa[71:48]));
          uy  <= 25'(signed'(pb[47:24])) - 25'(signed'(pa[47:24]));
          uz  <= 25'(signed'(pb[23:0]))  - 25'(signed'(pa[23:0]));
          wx  <= 25'(signed'(pc[71:48])) - 25'(signed'(pa[71:48]));
          wy  <= 25'(signed'(pc[47:24])) - 25'(signed'(pa[47:24]));
          wz  <= 25'(signed'(pc[23:0]))  - 25'(signed'(pa[23:0]));
          cnt <= '0;
          if (tri_bad || !pa[POS_WORD_W-1] || !pb[POS_WORD_W-1] || !pc[POS_WORD_W-1]) begin
            res_status <= ST_BAD;
            state      <= S_FIN;
          end else begin
            state <= S_CROSS;
          end
        end
        S_CROSS: begin
          prod <= opa * opb;
          cnt  <= cnt + 3'd1;
          priority case (cnt)
            3'd1:    nx <= 51'(prod);
            3'd2:    nx <= nx - 51'(prod);
            3'd3:    ny <= 51'(prod);
            3'd4:    ny <= ny - 51'(prod);
            3'd5:    nz <= 51'(prod);
            3'd6:    nz <= nz - 51'(prod);
            default: ;
          endcase
          if (cnt == 3'd6) begin
            cj    <= '0;
            state <= S_ACC_RD;
          end
        end
        S_ACC_RD: begin
          state <= S_ACC_WR;
        end
        S_ACC_WR: begin
          if (cj == 2'd2) begin
            state <= S_FIN;
          end else begin
            cj    <= cj + 2'd1;
            state <= S_ACC_RD;
          end
        end
        S_RD_RD: begin
          state <= S_RD_CHK;
        end
        S_RD_CHK: begin
          if (slot_bad || !p_rdata[POS_WORD_W-1]) begin
            res_status <= ST_BAD;
            state      <= S_FIN;
          end else begin
            state <= S_RD_WAIT;
          end
        end
        S_RD_WAIT: begin
          if (nrsp.done) begin
            res_status <= nrsp.zero ? ST_ZERO : ST_OK;
            res_x      <= nrsp.x;
            res_y      <= nrsp.y;
            res_z      <= nrsp.z;
            state      <= S_FIN;
          end
        end
        S_FIN: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid       <= 1'b1;
            rsp.data.status <= res_status;
            rsp.data.norm_x <= res_x;
            rsp.data.norm_y <= res_y;
            rsp.data.norm_z <= res_z;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
